// ===== src/btda_pkg.sv =====
`default_nettype none
package btda_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NIBBLES    = 10;
  localparam int BCD_W      = 4 * NIBBLES;
  localparam int CNT_W      = $clog2(VALUE_BITS);

  localparam logic [5:0] ASCII_ZERO = 6'd48;

  // Finished conversion handed from the dabble shifter to the emitter
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [3:0]       width;
  } conv_t;

endpackage
`default_nettype wire

// ===== src/btda_dabble.sv =====
`default_nettype none
module btda_dabble (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [31:0]    value,
  input  wire logic [3:0]     min_width,
  output logic                conv_valid,
  input  wire logic           conv_ready,
  output btda_pkg::conv_t     conv
);
  import btda_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_HOLD  = 2'd2;

  logic [1:0]            state;
  logic [VALUE_BITS-1:0] shreg;
  logic [BCD_W-1:0]      bcd;
  logic [BCD_W-1:0]      adj;
  logic [CNT_W-1:0]      cnt;
  logic [3:0]            width;

  // add 3 to every digit of five or more before the shift
  always_comb begin
    for (int n = 0; n < NIBBLES; n++) begin
      adj[4*n +: 4] = (bcd[4*n +: 4] >= 4'd5) ? bcd[4*n +: 4] + 4'd3 : bcd[4*n +: 4];
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign conv_valid = (state == ST_HOLD);
  assign conv.bcd   = bcd;
  assign conv.width = width;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_SHIFT;
          end
        end
        ST_SHIFT: begin
          if (cnt == CNT_W'(VALUE_BITS - 1)) begin
            state <= ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (conv_ready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      shreg <= value[VALUE_BITS-1:0];
      bcd   <= '0;
      cnt   <= '0;
      width <= min_width;
    end else if (state == ST_SHIFT) begin
      bcd   <= {adj[BCD_W-2:0], shreg[VALUE_BITS-1]};
      shreg <= shreg << 1;
      cnt   <= cnt + 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/btda_emit.sv =====
`default_nettype none
module btda_emit (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             conv_valid,
  output logic                  conv_ready,
  input  wire btda_pkg::conv_t  conv,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic [5:0]            char_code,
  output logic                  last_char,
  output logic [3:0]            total_length
);
  import btda_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIZE = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]       state;
  logic [BCD_W-1:0] bcd;
  logic [3:0]       width;
  logic [3:0]       chars_left;
  logic [3:0]       pads_left;
  logic [3:0]       total;
  logic [3:0]       digits;
  logic [3:0]       nib;
  logic [3:0]       pos;
  logic             can_load;

  function automatic logic [3:0] nibble_at(input logic [BCD_W-1:0] b, input logic [3:0] idx);
    logic [3:0] r;
    r = 4'd0;
    for (int n = 0; n < NIBBLES; n++) begin
      if (idx == 4'(n)) begin
        r = b[4*n +: 4];
      end
    end
    return r;
  endfunction

  // highest nonzero digit sets the count; zero still gives one digit
  always_comb begin
    digits = 4'd1;
    for (int n = 1; n < NIBBLES; n++) begin
      if (bcd[4*n +: 4] != 4'd0) begin
        digits = 4'(n + 1);
      end
    end
  end

  assign pos        = chars_left - 4'd1;
  assign nib        = nibble_at(bcd, pos);
  assign conv_ready = (state == ST_IDLE);
  assign can_load   = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      // a new beat replaces the one leaving; otherwise drop valid once taken
      if (state == ST_EMIT && can_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (conv_valid) begin
            state <= ST_SIZE;
          end
        end
        ST_SIZE: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (can_load && chars_left == 4'd1) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (conv_valid) begin
          bcd   <= conv.bcd;
          width <= conv.width;
        end
      end
      ST_SIZE: begin
        if (width > digits) begin
          pads_left  <= width - digits;
          total      <= width;
          chars_left <= width;
        end else begin
          pads_left  <= 4'd0;
          total      <= digits;
          chars_left <= digits;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          char_code    <= (pads_left != 4'd0) ? ASCII_ZERO : ASCII_ZERO + {2'b00, nib};
          last_char    <= (chars_left == 4'd1);
          total_length <= total;
          chars_left   <= chars_left - 4'd1;
          if (pads_left != 4'd0) begin
            pads_left <= pads_left - 4'd1;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== src/binary_to_decimal_ascii_padded_unit.sv =====
`default_nettype none
// Converts an unsigned 32-bit value to decimal ASCII text with no leading
// zeros ('0' for zero), left padded with '0' up to min_width characters,
// and sends it one character per beat, most significant first; last_char
// marks the final beat and total_length gives the character count on every
// beat. The conversion is a bit-serial double dabble that takes the value,
// shifts in one input bit per cycle and holds the result until the emitter
// takes it; the emitter then sizes the text, and characters leave at one per
// cycle while the output is not stalled. The emitter works on one number while
// the shifter converts the next, so a new value can be taken while the text of
// the previous one is still being sent; a stalled output holds the emitter and,
// behind it, the shifter and the input.
module binary_to_decimal_ascii_padded_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] value,
  input  wire logic [3:0]  min_width,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [5:0]       char_code,
  output logic             last_char,
  output logic [3:0]       total_length
);
  import btda_pkg::*;

  logic  conv_valid;
  logic  conv_ready;
  conv_t conv;

  btda_dabble u_dabble (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .min_width  (min_width),
    .conv_valid (conv_valid),
    .conv_ready (conv_ready),
    .conv       (conv)
  );

  btda_emit u_emit (
    .clk          (clk),
    .rst          (rst),
    .conv_valid   (conv_valid),
    .conv_ready   (conv_ready),
    .conv         (conv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .total_length (total_length)
  );

  // hold a finished conversion until the emitter takes it
  a_conv_hold: assert property (@(posedge clk) disable iff (rst)
    conv_valid && !conv_ready |=> conv_valid && $stable(conv.bcd) && $stable(conv.width))
    else $error("conversion changed while waiting for the emitter");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("shifter took a second value while converting");

  a_char_digit: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> char_code >= ASCII_ZERO && char_code <= ASCII_ZERO + 6'd9)
    else $error("character is not a decimal digit");

  a_length_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> total_length != 4'd0)
    else $error("beat sent with zero length");

endmodule
`default_nettype wire

// ===== sim/binary_to_decimal_ascii_padded_unit_test.sv =====
`default_nettype none
module binary_to_decimal_ascii_padded_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import btda_pkg::*;

  typedef struct packed {
    logic [5:0] code;
    logic       last;
    logic [3:0] len;
  } char_beat_t;

  // Expected text of every accepted number, one entry per character beat
  class text_scoreboard;
    char_beat_t text_q[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function int pending();
      return text_q.size();
    endfunction

    // Convert the number to decimal digits and queue its padded text
    function void note_number(logic [31:0] num, logic [3:0] width);
      logic [BCD_W-1:0] bcd;
      int               digits;
      int               total;
      int               pads;
      char_beat_t       beat;
      bcd = '0;
      for (int b = VALUE_BITS - 1; b >= 0; b--) begin
        for (int n = 0; n < NIBBLES; n++) begin
          if (bcd[4*n +: 4] >= 4'd5) bcd[4*n +: 4] = bcd[4*n +: 4] + 4'd3;
        end
        bcd = {bcd[BCD_W-2:0], num[b]};
      end
      digits = 1;
      for (int n = NIBBLES - 1; n > 0; n--) begin
        if (bcd[4*n +: 4] != 4'd0) begin
          digits = n + 1;
          break;
        end
      end
      total = (int'(width) > digits) ? int'(width) : digits;
      pads  = total - digits;
      for (int k = 0; k < total; k++) begin
        if (k < pads) beat.code = ASCII_ZERO;
        else          beat.code = ASCII_ZERO + 6'(bcd[4*(total-1-k) +: 4]);
        beat.last = (k == total - 1);
        beat.len  = 4'(total);
        text_q.push_back(beat);
      end
    endfunction

    function void check_char(logic [5:0] code, logic last, logic [3:0] len);
      char_beat_t exp_beat;
      if (text_q.size() == 0) begin
        $error("unexpected character beat: char_code %0d last_char %0d total_length %0d",
               code, last, len);
        errors++;
        return;
      end
      exp_beat = text_q.pop_front();
      if (code !== exp_beat.code) begin
        $error("char_code: expected %0d, actual %0d", exp_beat.code, code);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("last_char: expected %0d, actual %0d", exp_beat.last, last);
        errors++;
      end
      if (len !== exp_beat.len) begin
        $error("total_length: expected %0d, actual %0d", exp_beat.len, len);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] value = '0;
  logic [3:0]  min_width = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  char_code;
  logic        last_char;
  logic [3:0]  total_length;

  text_scoreboard sb;
  bit             tx_gaps = 1'b1;
  bit             rx_gaps = 1'b1;
  bit             hold_req = 1'b0;

  binary_to_decimal_ascii_padded_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .min_width    (min_width),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .char_code    (char_code),
    .last_char    (last_char),
    .total_length (total_length)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("binary_to_decimal_ascii_padded_unit_test: FAIL");
    $finish;
  end

  // Offer one number; return at the edge that takes it, valid still high
  task automatic send_number(input logic [31:0] num, input logic [3:0] width);
    if (tx_gaps && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    value     <= num;
    min_width <= width;
    do @(posedge clk); while (in_stall);
    sb.note_number(num, width);
  endtask

  function automatic logic [31:0] pick_number();
    int unsigned pow;
    pow = 10 ** $urandom_range(1, 9);
    case ($urandom_range(3))
      0:       return $urandom;
      1:       return $urandom_range(0, 999);
      2:       return pow - 1 + $urandom_range(0, 2);
      default: return $urandom_range(0, pow - 1);
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_number(pick_number(), 4'($urandom_range(0, 15)));
  endtask

  // Receiver: check each beat, stall at random or for a long hold-off
  initial begin
    int hold_cycles;
    hold_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) sb.check_char(char_code, last_char, total_length);
      if (hold_req) begin
        hold_req    = 1'b0;
        hold_cycles = 400;
      end
      if (hold_cycles > 0) begin
        out_stall <= 1'b1;
        hold_cycles--;
      end else begin
        out_stall <= rx_gaps && ($urandom_range(99) < 22);
      end
    end
  end

  initial begin
    sb = new();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero, full scale, decade edges, padding below, at and above digit count
    send_number(32'd0,          4'd0);
    send_number(32'd0,          4'd1);
    send_number(32'd0,          4'd15);
    send_number(32'd9,          4'd0);
    send_number(32'd10,         4'd0);
    send_number(32'd7,          4'd15);
    send_number(32'hFFFF_FFFF,  4'd0);
    send_number(32'hFFFF_FFFF,  4'd9);
    send_number(32'hFFFF_FFFF,  4'd10);
    send_number(32'hFFFF_FFFF,  4'd15);
    send_number(32'd999999999,  4'd0);
    send_number(32'd1000000000, 4'd0);
    send_number(32'd1000000000, 4'd11);
    send_number(32'd12345,      4'd3);
    send_number(32'd12345,      4'd5);
    send_number(32'd12345,      4'd6);
    send_number(32'd100,        4'd2);
    send_number(32'h8000_0000,  4'd12);
    send_number(32'h5555_5555,  4'b1010);
    send_number(32'hAAAA_AAAA,  4'b0101);
    in_valid <= 1'b0;

    // pause until every character is back
    do @(posedge clk); while (sb.pending() != 0);

    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    send_random(40);

    tx_gaps  = 1'b1;
    rx_gaps  = 1'b1;
    hold_req = 1'b1;
    send_random(60);
    in_valid <= 1'b0;

    do @(posedge clk); while (sb.pending() != 0);
    repeat (60) @(posedge clk);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("binary_to_decimal_ascii_padded_unit_test: PASS");
    end else begin
      $display("binary_to_decimal_ascii_padded_unit_test: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
src/btda_pkg.sv
src/btda_dabble.sv
src/btda_emit.sv
src/binary_to_decimal_ascii_padded_unit.sv
sim/binary_to_decimal_ascii_padded_unit_test.sv
